### rtl/core/mec_pkg.sv
// Shared types and constants for the Mandelbrot escape counter.
`default_nettype none

package mec_pkg;

    // Sequencer states: one iteration walks the three products and the update
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_XY,
        ST_UPDATE
    } t_state;

    // Fixed field widths
    localparam int IN_W    = 32;
    localparam int COUNT_W = 12;

    // Iteration limit after reset
    localparam logic [COUNT_W-1:0] RESET_MAX_ITER = 12'd511;

    // Escape radius squared is 4, i.e. 2**2
    localparam int RADIUS_SQ_LOG2 = 2;

endpackage

`default_nettype wire

### rtl/core/mec_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module mec_mul #(
    parameter int W = 32
) (
    input  wire logic                  i_clk,
    input  wire logic signed [W-1:0]   i_a,
    input  wire logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0]      o_prod
);

    logic signed [2*W-1:0] r_prod;

    // Register the full-width product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### rtl/core/mec_sat.sv
// Signed saturation from a wide value down to a narrower one.
`default_nettype none

module mec_sat #(
    parameter int IN_W  = 64,
    parameter int OUT_W = 32
) (
    input  wire logic signed [IN_W-1:0] i_value,
    output logic signed [OUT_W-1:0]     o_value
);

    logic [IN_W-OUT_W:0] top;
    logic                fits;

    // Value fits when all bits from the output sign bit upward agree
    assign top  = i_value[IN_W-1:OUT_W-1];
    assign fits = (&top) | ~(|top);

    always_comb begin
        if (fits) begin
            o_value = i_value[OUT_W-1:0];
        end else if (i_value[IN_W-1]) begin
            o_value = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            o_value = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

### rtl/core/mandelbrot_escape_counter_core.sv
// Top level of the Mandelbrot escape counter: sequencer around one shared multiplier.
//
// Usage:
//   Raise start with i_c_real / i_c_imag (signed fixed point, FRAC_BITS
//   fraction bits). The item is taken at a clock edge where start is high
//   and busy is low. The core iterates z = z*z + c from z = c until |z|^2
//   reaches 4 or the count reaches the iteration limit.
//   The result appears on o_escape_count with o_done high for one cycle;
//   busy is already low in that cycle, so a new item can be taken then.
//   The receiver cannot hold results off.
// Sequencing:
//   Each iteration walks three passes through the one shared multiplier
//   (x*x, y*y, x*y) and one update step. An item that stops on the limit
//   finishes in ST_MUL_XX, one that escapes in ST_MUL_XY. At the reset
//   limit of 511, a point that never escapes occupies the core for 511
//   iterations; busy stays high until the item finishes.
// Configuration:
//   i_cfg_we / i_cfg_wdata write the iteration limit; write it only while
//   the core is idle. Reset (synchronous, active low) sets the limit to 511
//   and returns the core to idle with no result pending.
`default_nettype none

module mandelbrot_escape_counter_core
    import mec_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [IN_W-1:0]    i_c_real,
    input  wire logic signed [IN_W-1:0]    i_c_imag,
    input  wire logic                      i_cfg_we,
    input  wire logic [COUNT_W-1:0]        i_cfg_wdata,
    output logic                           o_done,
    output logic [COUNT_W-1:0]             o_escape_count
);

    localparam int PROD_W   = 2 * DATA_WIDTH;
    localparam int ACC_W    = 2 * DATA_WIDTH + FRAC_BITS + 3;
    localparam int EXT_W    = IN_W + DATA_WIDTH;
    localparam int LIMIT_SH = 2 * FRAC_BITS + RADIUS_SQ_LOG2;

    t_state r_state, n_state;

    logic [COUNT_W-1:0]           r_max_iter;
    logic [COUNT_W-1:0]           r_count;
    logic signed [DATA_WIDTH-1:0] r_cr, r_ci, r_x, r_y;
    logic signed [PROD_W-1:0]     r_xx, r_yy;
    logic                         r_done;
    logic [COUNT_W-1:0]           r_result;

    logic                         accept;
    logic                         finish;
    logic                         escape;
    logic                         below_limit;
    logic signed [DATA_WIDTH-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]     prod;
    logic [PROD_W:0]              mag_sum;

    logic signed [EXT_W-1:0]      ext_real, ext_imag;
    logic signed [DATA_WIDTH-1:0] sat_real, sat_imag;

    logic signed [ACC_W-1:0]      acc_re, acc_im;
    logic signed [ACC_W-1:0]      sh_re, sh_im;
    logic signed [DATA_WIDTH-1:0] new_x, new_y;

    assign accept = start && (r_state == ST_IDLE);

    // Saturate the input point to the data width
    assign ext_real = EXT_W'(i_c_real);
    assign ext_imag = EXT_W'(i_c_imag);

    mec_sat #(.IN_W(EXT_W), .OUT_W(DATA_WIDTH)) u_sat_cr (
        .i_value (ext_real),
        .o_value (sat_real)
    );

    mec_sat #(.IN_W(EXT_W), .OUT_W(DATA_WIDTH)) u_sat_ci (
        .i_value (ext_imag),
        .o_value (sat_imag)
    );

    // Steer the shared multiplier by sequencer state
    always_comb begin
        unique case (r_state)
            ST_MUL_XX: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            ST_MUL_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_y;
            end
        endcase
    end

    mec_mul #(.W(DATA_WIDTH)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Escape test: x*x held in r_xx, y*y on the product register
    assign mag_sum = {1'b0, r_xx} + {1'b0, prod};
    assign escape  = |(mag_sum >> LIMIT_SH);

    assign below_limit = (r_count < r_max_iter);

    // New z: (xx - yy + cr) >> F and (2xy + ci) >> F, floor then saturate
    assign acc_re = ACC_W'(r_xx) - ACC_W'(r_yy) + (ACC_W'(r_cr) <<< FRAC_BITS);
    assign acc_im = (ACC_W'(prod) <<< 1) + (ACC_W'(r_ci) <<< FRAC_BITS);
    assign sh_re  = acc_re >>> FRAC_BITS;
    assign sh_im  = acc_im >>> FRAC_BITS;

    mec_sat #(.IN_W(ACC_W), .OUT_W(DATA_WIDTH)) u_sat_x (
        .i_value (sh_re),
        .o_value (new_x)
    );

    mec_sat #(.IN_W(ACC_W), .OUT_W(DATA_WIDTH)) u_sat_y (
        .i_value (sh_im),
        .o_value (new_y)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and finish decision
    always_comb begin
        n_state = r_state;
        finish  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MUL_XX;
                end
            end
            ST_MUL_XX: begin
                if (below_limit) begin
                    n_state = ST_MUL_YY;
                end else begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_MUL_YY: begin
                n_state = ST_MUL_XY;
            end
            ST_MUL_XY: begin
                if (escape) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_MUL_XX;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Iteration limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= RESET_MAX_ITER;
        end else if (i_cfg_we) begin
            r_max_iter <= i_cfg_wdata;
        end
    end

    // Datapath: load the point, capture products, advance z and the count
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cr    <= sat_real;
            r_ci    <= sat_imag;
            r_x     <= sat_real;
            r_y     <= sat_imag;
            r_count <= '0;
        end
        if (r_state == ST_MUL_YY) begin
            r_xx <= prod;
        end
        if (r_state == ST_MUL_XY) begin
            r_yy <= prod;
        end
        if (r_state == ST_UPDATE) begin
            r_x     <= new_x;
            r_y     <= new_y;
            r_count <= r_count + 1'b1;
        end
    end

    // Result strobe and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_result <= r_count;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_escape_count = r_result;

endmodule

`default_nettype wire

### rtl/core/mec_checker.sv
// Port-level checks for the Mandelbrot escape counter, bound to the top level.
`default_nettype none

module mec_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done
);

    // A taken item keeps the core busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after taking an item");

    // The result strobe comes with the core already idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Busy drops only together with a result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

endmodule

bind mandelbrot_escape_counter_core mec_checker u_mec_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

`default_nettype wire
